// ===== hw/rtl/lkv_pkg.sv =====
// Package with the shared types and constants of the LRU key-value cache.
package lkv_pkg;

    localparam int KEY_W = 32;
    localparam int VAL_W = 32;
    localparam int CFG_W = 5;

    localparam logic [CFG_W-1:0] CAP_RESET  = 5'd16;
    localparam logic [VAL_W-1:0] MISS_VALUE = {VAL_W{1'b1}};

    localparam logic REQ_GET = 1'b0;
    localparam logic REQ_SET = 1'b1;

    // One cache line: position in the chain is its recency rank.
    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } t_entry;

    // Control broadcast from the sequencer to every cell.
    typedef struct packed {
        logic capture;   // accept beat: compare the incoming key
        logic commit;    // apply the shift for the pending request
        logic hit_any;   // some cell matched
        logic insert_ok; // a set that misses may insert
        logic full;      // held count at or above the capacity
    } t_cell_ctl;

endpackage

// ===== hw/rtl/lkv_if.sv =====
// Valid/ready channel interfaces for requests and responses.
interface lkv_req_if;
    logic                     valid;
    logic                     ready;
    logic                     req_type;
    logic signed [31:0]       lookup_key;
    logic signed [31:0]       store_value;

    modport source (output valid, output req_type, output lookup_key, output store_value,
                    input ready);
    modport sink   (input valid, input req_type, input lookup_key, input store_value,
                    output ready);
endinterface

interface lkv_rsp_if;
    logic                     valid;
    logic                     ready;
    logic                     hit;
    logic signed [31:0]       read_value;

    modport source (output valid, output hit, output read_value, input ready);
    modport sink   (input valid, input hit, input read_value, output ready);
endinterface

// ===== hw/rtl/lru_key_value_cache_unit.sv =====
// Top level of the LRU key-value cache: sequencer, capacity register and cell chain.
// Each request is accepted in the idle state, where every cell compares the key;
// in the execute state the chain shifts and the response register loads.
// A new request is taken only once the last one has finished (ready in idle only);
// a get whose response register is still occupied waits in the execute state.
// Synchronous active-low reset clears all valid marks, the held count and the
// response valid flag, and sets the capacity to sixteen entries.
module lru_key_value_cache_unit
    import lkv_pkg::*;
#(
    parameter int ENTRIES = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    lkv_req_if.sink          req_if,
    lkv_rsp_if.source        rsp_if
);

    localparam int HW   = $clog2(ENTRIES + 1);
    localparam int CMPW = (HW > CFG_W) ? HW : CFG_W;
    localparam logic [CMPW-1:0] ENTRIES_C = CMPW'(ENTRIES);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic             r_state;
    logic             r_req_type;
    logic [KEY_W-1:0] r_req_key;
    logic [VAL_W-1:0] r_req_value;
    logic [CFG_W-1:0] r_cap;
    logic [HW-1:0]    r_held;
    logic             r_rsp_valid;
    logic             r_rsp_hit;
    logic [VAL_W-1:0] r_rsp_value;

    logic             w_accept;
    logic             w_commit;
    logic [CMPW-1:0]  w_cap_eff;
    logic [CMPW-1:0]  w_cap_ext;
    t_cell_ctl        w_ctl;
    t_entry           w_new;

    t_entry           w_ent   [ENTRIES];
    logic             w_tail  [ENTRIES+1];
    logic [VAL_W-1:0] w_hval  [ENTRIES+1];
    logic [ENTRIES-1:0] w_match_vec;
    logic [ENTRIES-1:0] w_valid_vec;

    // Request side: one request in flight at a time.
    assign req_if.ready = (r_state == ST_IDLE);
    assign w_accept     = req_if.valid && req_if.ready;

    // A set always finishes; a get finishes once the response register is free.
    assign w_commit = (r_state == ST_EXEC) &&
                      ((r_req_type == REQ_SET) || !r_rsp_valid || rsp_if.ready);

    // Capacity above the number of cells saturates to the number of cells.
    assign w_cap_ext = CMPW'(r_cap);
    assign w_cap_eff = (w_cap_ext > ENTRIES_C) ? ENTRIES_C : w_cap_ext;

    always_comb begin
        w_ctl.capture   = w_accept;
        w_ctl.commit    = w_commit;
        w_ctl.hit_any   = w_tail[0];
        w_ctl.insert_ok = (r_req_type == REQ_SET) && (w_cap_eff != '0);
        w_ctl.full      = CMPW'(r_held) >= w_cap_eff;
    end

    // The entry that lands at the most recent position: the request key, with the
    // new value on a set and the found value on a get hit.
    always_comb begin
        w_new.valid = 1'b1;
        w_new.key   = r_req_key;
        w_new.value = (r_req_type == REQ_SET) ? r_req_value : w_hval[0];
    end

    assign w_tail[ENTRIES] = 1'b0;
    assign w_hval[ENTRIES] = '0;

    // Cell 0 is the most recent entry; the valid run is always contiguous from it.
    for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
        t_entry w_left;
        if (i == 0) begin : g_head
            assign w_left = w_new;
        end else begin : g_body
            assign w_left = w_ent[i-1];
        end

        lkv_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (w_ctl),
            .i_key       (req_if.lookup_key),
            .i_left      (w_left),
            .i_tail      (w_tail[i+1]),
            .i_hit_value (w_hval[i+1]),
            .o_entry     (w_ent[i]),
            .o_match     (w_match_vec[i]),
            .o_tail      (w_tail[i]),
            .o_hit_value (w_hval[i])
        );

        assign w_valid_vec[i] = w_ent[i].valid;
    end

    // Sequencer, capacity register and held count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cap   <= CAP_RESET;
            r_held  <= '0;
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_state <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    if (w_commit) begin
                        r_state <= ST_IDLE;
                        // A new key only grows the count while below capacity.
                        if (!w_ctl.hit_any && w_ctl.insert_ok && !w_ctl.full) begin
                            r_held <= r_held + HW'(1);
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req_type  <= req_if.req_type;
            r_req_key   <= req_if.lookup_key;
            r_req_value <= req_if.store_value;
        end
    end

    // Response register: one beat per get.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp_valid <= 1'b0;
        end else if (w_commit && (r_req_type == REQ_GET)) begin
            r_rsp_valid <= 1'b1;
        end else if (rsp_if.ready) begin
            r_rsp_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_commit && (r_req_type == REQ_GET)) begin
            r_rsp_hit   <= w_tail[0];
            r_rsp_value <= w_tail[0] ? w_hval[0] : MISS_VALUE;
        end
    end

    assign rsp_if.valid      = r_rsp_valid;
    assign rsp_if.hit        = r_rsp_hit;
    assign rsp_if.read_value = r_rsp_value;

    // Keys are unique in the cache, so at most one cell can match.
    a_single_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EXEC) |-> $onehot0(w_match_vec))
        else $error("more than one cell matched the request key");

    // The held count tracks the number of valid cells.
    a_held_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_valid_vec) == 32'(r_held))
        else $error("held count differs from the valid cells");

    // Valid cells form one run starting at the most recent position.
    a_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((w_valid_vec & (w_valid_vec + ENTRIES'(1))) == '0))
        else $error("valid cells are not contiguous from the head");

    // A finished get always presents a response beat in the next cycle.
    a_get_responds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_commit && (r_req_type == REQ_GET)) |=> rsp_if.valid)
        else $error("get finished without a response beat");

endmodule

// ===== hw/rtl/lkv_cell.sv =====
// One cell of the recency chain: holds one entry and shifts from its left neighbor.
module lkv_cell
    import lkv_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cell_ctl        i_ctl,
    input  logic [KEY_W-1:0] i_key,
    input  t_entry           i_left,
    input  logic             i_tail,
    input  logic [VAL_W-1:0] i_hit_value,
    output t_entry           o_entry,
    output logic             o_match,
    output logic             o_tail,
    output logic [VAL_W-1:0] o_hit_value
);

    t_entry r_entry;
    logic   r_match;
    logic   n_shift;

    // A hit moves every entry up to and including the hit one; an insert moves
    // the whole valid run, dropping the last entry when the cache is full.
    always_comb begin
        if (i_ctl.hit_any) begin
            n_shift = r_match | i_tail;
        end else begin
            n_shift = i_ctl.insert_ok & (i_ctl.full ? r_entry.valid : i_left.valid);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry.valid <= 1'b0;
            r_match       <= 1'b0;
        end else begin
            if (i_ctl.capture) begin
                r_match <= r_entry.valid && (r_entry.key == i_key);
            end
            if (i_ctl.commit && n_shift) begin
                r_entry.valid <= i_left.valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.commit && n_shift) begin
            r_entry.key   <= i_left.key;
            r_entry.value <= i_left.value;
        end
    end

    assign o_entry     = r_entry;
    assign o_match     = r_match;
    assign o_tail      = r_match | i_tail;
    assign o_hit_value = i_hit_value | (r_match ? r_entry.value : '0);

endmodule

// ===== dv/tb_lru_key_value_cache_unit.sv =====
// Self-checking testbench for the LRU key-value cache: random stimulus, shadow cache, response check.
module tb_lru_key_value_cache_unit
    import lkv_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS        = 16;
    localparam int DRAIN_CYCLES = 8;   // leave room for the last set to finish inside the block
    localparam int KEY_POOL     = 32;

    // One request beat and one expected lookup answer.
    typedef struct packed {
        logic             kind;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } t_cache_req;

    typedef struct packed {
        logic             hit;
        logic [VAL_W-1:0] value;
    } t_lookup_rsp;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [CFG_W-1:0] i_cfg_wdata;

    lkv_req_if req_if ();
    lkv_rsp_if rsp_if ();

    lru_key_value_cache_unit #(
        .ENTRIES(SLOTS)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .req_if     (req_if),
        .rsp_if     (rsp_if)
    );

    // Shadow copy of the cache contents. A rank of zero marks the most recent
    // valid entry; the least recent valid entry holds rank held_count - 1.
    logic [KEY_W-1:0] shadow_key   [SLOTS];
    logic [VAL_W-1:0] shadow_val   [SLOTS];
    logic             shadow_vld   [SLOTS];
    logic [3:0]       shadow_rank  [SLOTS];
    logic [4:0]       shadow_held;
    logic [CFG_W-1:0] shadow_cap;

    t_cache_req       pending_reqs [$];   // requests waiting for the driver
    t_lookup_rsp      lookups_due  [$];   // answers owed for accepted gets
    t_cache_req       on_wire;            // request currently offered on the channel
    t_lookup_rsp      oldest_due;
    logic [KEY_W-1:0] key_pool     [KEY_POOL];
    int               idle_pct;
    int               errors;

    // Free-running clock, 20 ns period.
    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // Returns the slot holding the key, or -1 when no valid entry matches.
    function automatic int cache_find(input logic [KEY_W-1:0] key);
        for (int i = 0; i < SLOTS; i++) begin
            if (shadow_vld[i] && shadow_key[i] == key) begin
                return i;
            end
        end
        return -1;
    endfunction

    // Moves a slot to the front; every valid entry that was more recent ages by one.
    function automatic void cache_promote(input int slot);
        logic [3:0] r;
        r = shadow_rank[slot];
        for (int i = 0; i < SLOTS; i++) begin
            if (shadow_vld[i] && shadow_rank[i] < r) begin
                shadow_rank[i]++;
            end
        end
        shadow_rank[slot] = 4'd0;
    endfunction

    function automatic t_lookup_rsp cache_get(input logic [KEY_W-1:0] key);
        t_lookup_rsp rsp;
        int          slot;
        slot = cache_find(key);
        if (slot >= 0) begin
            cache_promote(slot);
            rsp.hit   = 1'b1;
            rsp.value = shadow_val[slot];
        end else begin
            rsp.hit   = 1'b0;
            rsp.value = MISS_VALUE;
        end
        return rsp;
    endfunction

    // A set updates a held key in place, or else inserts, evicting the least
    // recent entry first once the held count has reached the capacity. The
    // capacity saturates at the number of slots; zero blocks every insertion.
    function automatic void cache_set(input logic [KEY_W-1:0] key,
                                      input logic [VAL_W-1:0] value);
        logic [4:0] limit;
        int         slot;
        int         free_slot;
        slot      = cache_find(key);
        free_slot = -1;
        limit     = (shadow_cap > SLOTS) ? 5'(SLOTS) : 5'(shadow_cap);
        if (slot >= 0) begin
            shadow_val[slot] = value;
            cache_promote(slot);
            return;
        end
        if (limit == 5'd0) begin
            return;
        end
        if (shadow_held >= limit && shadow_held > 5'd0) begin
            for (int i = 0; i < SLOTS; i++) begin
                if (shadow_vld[i] && {1'b0, shadow_rank[i]} == shadow_held - 5'd1) begin
                    shadow_vld[i]  = 1'b0;
                    shadow_rank[i] = 4'd0;
                    shadow_held--;
                    break;
                end
            end
        end
        for (int i = 0; i < SLOTS; i++) begin
            if (!shadow_vld[i]) begin
                free_slot = i;
                break;
            end
        end
        if (free_slot < 0) begin
            return;
        end
        for (int i = 0; i < SLOTS; i++) begin
            if (shadow_vld[i]) begin
                shadow_rank[i]++;
            end
        end
        shadow_key[free_slot]  = key;
        shadow_val[free_slot]  = value;
        shadow_vld[free_slot]  = 1'b1;
        shadow_rank[free_slot] = 4'd0;
        shadow_held++;
    endfunction

    // Request driver. The beat accepted at this edge goes through the shadow
    // cache first; then the next request is offered, or the channel idles at
    // random. Valid gets at most one assignment per edge, so a back-to-back
    // request keeps it high without a glitch.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else begin
            if (req_if.valid && req_if.ready) begin
                if (on_wire.kind == REQ_GET) begin
                    lookups_due.push_back(cache_get(on_wire.key));
                end else begin
                    cache_set(on_wire.key, on_wire.value);
                end
            end
            if (!req_if.valid || req_if.ready) begin
                if (pending_reqs.size() != 0 && $urandom_range(99) >= idle_pct) begin
                    on_wire = pending_reqs.pop_front();
                    req_if.valid       <= 1'b1;
                    req_if.req_type    <= on_wire.kind;
                    req_if.lookup_key  <= on_wire.key;
                    req_if.store_value <= on_wire.value;
                end else begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    // Response monitor. Each accepted beat is matched against the oldest
    // answer owed; ready is dropped at random to stall the response register.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else begin
            if (rsp_if.valid && rsp_if.ready) begin
                if (lookups_due.size() == 0) begin
                    $display("%0t: response with no get outstanding: hit %0b value %h",
                             $time, rsp_if.hit, rsp_if.read_value);
                    errors++;
                end else begin
                    oldest_due = lookups_due.pop_front();
                    if (rsp_if.hit !== oldest_due.hit
                            || rsp_if.read_value !== oldest_due.value) begin
                        $display("%0t: get mismatch: expected hit %0b value %h, actual hit %0b value %h",
                                 $time, oldest_due.hit, oldest_due.value,
                                 rsp_if.hit, rsp_if.read_value);
                        errors++;
                    end
                end
            end
            rsp_if.ready <= ($urandom_range(99) >= idle_pct);
        end
    end

    task automatic queue_req(input logic kind, input logic [KEY_W-1:0] key,
                             input logic [VAL_W-1:0] value);
        t_cache_req r;
        r.kind  = kind;
        r.key   = key;
        r.value = value;
        pending_reqs.push_back(r);
    endtask

    // Random traffic over a key window a little wider than the capacity, so
    // that hits, updates and evictions all happen; a few keys are pure noise.
    task automatic queue_random(input int count);
        int   window;
        logic kind;
        window = ((shadow_cap > SLOTS) ? SLOTS : int'(shadow_cap)) + 4;
        if (window > KEY_POOL - 1) begin
            window = KEY_POOL - 1;
        end
        for (int n = 0; n < count; n++) begin
            kind = ($urandom_range(99) < 45) ? REQ_SET : REQ_GET;
            if ($urandom_range(99) < 8) begin
                queue_req(kind, $urandom, $urandom);
            end else begin
                queue_req(kind, key_pool[$urandom_range(window)], $urandom);
            end
        end
    endtask

    // Holds off until every queued request has been taken and every get has
    // been answered, then lets the last set finish inside the block. The check
    // runs on the falling edge, after the driver's updates of the rising edge
    // have all landed.
    task automatic settle();
        while (pending_reqs.size() != 0 || req_if.valid || lookups_due.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // The capacity register is only written with the cache idle.
    task automatic write_capacity(input logic [CFG_W-1:0] cap);
        settle();
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= cap;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        shadow_cap   = cap;
    endtask

    // Ends a hung run.
    initial begin
        #2_000_000;
        $display("lru_key_value_cache_unit regression: fail");
        $finish;
    end

    initial begin
        logic [CFG_W-1:0] caps [11];

        i_rst_n            = 1'b0;
        i_cfg_we           = 1'b0;
        i_cfg_wdata        = '0;
        req_if.valid       = 1'b0;
        req_if.req_type    = REQ_GET;
        req_if.lookup_key  = '0;
        req_if.store_value = '0;
        rsp_if.ready       = 1'b0;
        errors             = 0;
        idle_pct           = 38;
        shadow_held        = '0;
        shadow_cap         = CAP_RESET;
        for (int i = 0; i < SLOTS; i++) begin
            shadow_vld[i]  = 1'b0;
            shadow_rank[i] = 4'd0;
            shadow_key[i]  = '0;
            shadow_val[i]  = '0;
        end

        // The key pool starts with the extremes of the signed range and the
        // all-ones key, which looks just like the miss value when it hits.
        key_pool[0] = 32'h8000_0000;
        key_pool[1] = 32'h7FFF_FFFF;
        key_pool[2] = 32'h0000_0000;
        key_pool[3] = 32'hFFFF_FFFF;
        key_pool[4] = $urandom;
        for (int i = 5; i < KEY_POOL; i++) begin
            // Some keys differ from a neighbor in one bit only, to catch a loose compare.
            key_pool[i] = ($urandom_range(3) == 0) ? key_pool[i-1] ^ (32'd1 << $urandom_range(31))
                                                   : $urandom;
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part at the reset capacity: a get on the empty cache, sets
        // of the extreme keys and values, hits on each, an update of a held
        // key, and a miss once entries are held.
        queue_req(REQ_GET, 32'h0000_0000, 32'h1234_5678);
        queue_req(REQ_SET, 32'h8000_0000, 32'h7FFF_FFFF);
        queue_req(REQ_SET, 32'h7FFF_FFFF, 32'h8000_0000);
        queue_req(REQ_SET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_req(REQ_SET, 32'h0000_0000, 32'h0000_0000);
        queue_req(REQ_GET, 32'h8000_0000, 32'h0000_0000);
        queue_req(REQ_GET, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        queue_req(REQ_GET, 32'hFFFF_FFFF, 32'h0000_0000);
        queue_req(REQ_SET, 32'h0000_0000, 32'h0000_007B);
        queue_req(REQ_GET, 32'h0000_0000, 32'h0000_0000);
        queue_req(REQ_GET, 32'h0000_0007, 32'h0000_0000);

        // Capacity dropped to one, below the four held entries: nothing goes at
        // once, but each later insertion evicts the least recent entry.
        write_capacity(5'd1);
        queue_req(REQ_SET, 32'h0000_000B, 32'h0000_0001);
        queue_req(REQ_SET, 32'h0000_0016, 32'h0000_0002);
        queue_req(REQ_GET, 32'h8000_0000, 32'h0000_0000);
        queue_req(REQ_GET, 32'h0000_0016, 32'h0000_0000);

        // Capacity zero: a new key is dropped, a held key is still updated.
        write_capacity(5'd0);
        queue_req(REQ_SET, 32'h0000_0021, 32'h0000_0003);
        queue_req(REQ_GET, 32'h0000_0021, 32'h0000_0000);
        queue_req(REQ_SET, 32'h0000_0016, 32'h0000_002C);
        queue_req(REQ_GET, 32'h0000_0016, 32'h0000_0000);

        // The largest register value saturates at the slot count.
        write_capacity(5'd31);
        queue_req(REQ_SET, 32'h0000_002C, 32'h0000_0004);
        queue_req(REQ_GET, 32'h0000_002C, 32'h0000_0000);

        // Random phases over a spread of capacities. Every write waits for the
        // cache to drain, which also makes the sender pause until all answers
        // are in. One phase runs with no idling on either side.
        caps = '{5'd16, 5'd2, 5'd8, 5'd17, 5'd1, 5'd4, 5'd0, 5'd12, 5'd3, 5'd16, 5'd16};
        caps[10] = 5'($urandom_range(1, 16));
        for (int p = 0; p < 11; p++) begin
            write_capacity(caps[p]);
            idle_pct = (p == 9) ? 0 : 38;
            queue_random(93);
        end

        settle();
        if (errors == 0) begin
            $display("lru_key_value_cache_unit regression: pass");
        end else begin
            $display("lru_key_value_cache_unit regression: fail");
        end
        $finish;
    end

endmodule
